### hw/rtl/cfml_pkg.sv
// Shared types and constants of the cylindrical field map lookup.
// Depends on nothing; every other file of the block but cfml_ram uses it by scoped names.
`default_nettype none

package cfml_pkg;

  // Map geometry and field width
  localparam int RadialBins = 150;
  localparam int AxialBins  = 150;
  localparam int FieldW     = 32;
  localparam int MapDepth   = RadialBins * AxialBins;
  localparam int AddrW      = $clog2(MapDepth);

  // Input and bin widths
  localparam int PosW  = 21;
  localparam int BinW  = 8;
  localparam int RLimW = 12;
  localparam int ZLimW = 8;
  localparam int SqW   = 2 * PosW;
  localparam int RootW = PosW;
  localparam int RemW  = RootW + 4;
  localparam int RbW   = 15;
  localparam int ZbW   = 11;
  localparam int SqrtSteps = RootW;

  // Reciprocal multipliers: floor(v/100) and floor(v/1000) for v below 2^21
  localparam logic [21:0] RbMul   = 22'd2684355;
  localparam int          RbShift = 28;
  localparam logic [20:0] ZbMul   = 21'd1073742;
  localparam int          ZbShift = 30;

  // Field split datapath
  localparam int MagW    = FieldW;
  localparam int ProdW   = MagW + PosW;
  localparam int LoW     = 26;
  localparam int HiW     = ProdW - LoW;
  localparam int Sq2W    = 2 * ProdW;
  localparam int RemSplW = Sq2W + 2;
  localparam int TW      = MagW + SqW;
  localparam int SplitSteps = MagW;

  // Configuration registers
  localparam int          CfgIdxW        = 1;
  localparam logic        CfgRadiusLimit = 1'b0;
  localparam logic        CfgAxialLimit  = 1'b1;
  localparam logic [RLimW-1:0] RadiusLimitRst = 12'd900;
  localparam logic [ZLimW-1:0] AxialLimitRst  = 8'd100;

  // Queue between front and back
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);

  // Classified item handed from front to back
  typedef struct packed {
    logic                   is_load;
    logic                   lok;
    logic [AddrW-1:0]       addr;
    logic [FieldW-1:0]      lrv;
    logic [FieldW-1:0]      lav;
    logic signed [PosW-1:0] x;
    logic signed [PosW-1:0] y;
    logic                   flip;
    logic [SqW-1:0]         s;
    logic                   hit;
    logic                   axis;
  } cfml_item_t;

endpackage

`default_nettype wire

### hw/rtl/cfml_ram.sv
// Generic single-port RAM with registered read.
// Depends on nothing.
`default_nettype none

module cfml_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write and registered read on one port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### hw/rtl/cfml_front.sv
// Front part: accepts items, computes radius and axial bins, classifies the point.
// Depends on cfml_pkg.
`default_nettype none

module cfml_front (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic                                in_op_i,
  input  wire logic signed [cfml_pkg::PosW-1:0]    in_x_i,
  input  wire logic signed [cfml_pkg::PosW-1:0]    in_y_i,
  input  wire logic signed [cfml_pkg::PosW-1:0]    in_z_i,
  input  wire logic [cfml_pkg::BinW-1:0]           in_lrb_i,
  input  wire logic [cfml_pkg::BinW-1:0]           in_lab_i,
  input  wire logic [cfml_pkg::FieldW-1:0]         in_lrv_i,
  input  wire logic [cfml_pkg::FieldW-1:0]         in_lav_i,
  input  wire logic [cfml_pkg::RLimW-1:0]          radius_limit_i,
  input  wire logic [cfml_pkg::ZLimW-1:0]          axial_limit_i,
  input  wire logic                                q_full_i,
  output logic                                     push_o,
  output cfml_pkg::cfml_item_t                     item_o
);

  localparam int SIn       = 0;
  localparam int SSq       = 1;
  localparam int SSum      = 2;
  localparam int SZb       = 3;
  localparam int SqrtFirst = 4;
  localparam int SRbm      = SqrtFirst + cfml_pkg::SqrtSteps;
  localparam int SCls      = SRbm + 1;
  localparam int NStg      = SCls + 1;

  typedef struct packed {
    logic                                is_load;
    logic signed [cfml_pkg::PosW-1:0]    x;
    logic signed [cfml_pkg::PosW-1:0]    y;
    logic signed [cfml_pkg::PosW-1:0]    z;
    logic [cfml_pkg::PosW-1:0]           zabs;
    logic                                zneg;
    logic                                flip;
    logic [cfml_pkg::BinW-1:0]           lrb;
    logic [cfml_pkg::BinW-1:0]           lab;
    logic [cfml_pkg::FieldW-1:0]         lrv;
    logic [cfml_pkg::FieldW-1:0]         lav;
    logic                                lok;
    logic [cfml_pkg::AddrW-1:0]          ladr;
    logic [cfml_pkg::SqW-1:0]            xx;
    logic [cfml_pkg::SqW-1:0]            yy;
    logic [cfml_pkg::SqW-1:0]            s;
    logic [cfml_pkg::SqW-1:0]            zprod;
    logic [cfml_pkg::ZbW-1:0]            za;
    logic [cfml_pkg::RemW-1:0]           rem;
    logic [cfml_pkg::RootW-1:0]          root;
    logic [cfml_pkg::SqW:0]              rbprod;
    logic                                hit;
    logic                                axis;
    logic [cfml_pkg::BinW-1:0]           col;
  } fe_t;

  fe_t             st_q [NStg];
  fe_t             st_d [NStg];
  logic [NStg-1:0] vld_q;
  logic            en;

  // Advance while the last stage is empty or the queue has room
  assign en         = !vld_q[NStg-1] || !q_full_i;
  assign in_ready_o = en;
  assign push_o     = vld_q[NStg-1] && !q_full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NStg-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      st_q <= st_d;
    end
  end

  // Capture the request
  always_comb begin
    st_d[SIn]         = '0;
    st_d[SIn].is_load = in_op_i;
    st_d[SIn].x       = in_x_i;
    st_d[SIn].y       = in_y_i;
    st_d[SIn].z       = in_z_i;
    st_d[SIn].lrb     = in_lrb_i;
    st_d[SIn].lab     = in_lab_i;
    st_d[SIn].lrv     = in_lrv_i;
    st_d[SIn].lav     = in_lav_i;
  end

  // Square the coordinates, take |z|, form the load address
  always_comb begin
    logic [cfml_pkg::PosW-1:0] xa;
    logic [cfml_pkg::PosW-1:0] ya;
    logic [15:0]               la;
    st_d[SSq] = st_q[SIn];
    xa = st_q[SIn].x[cfml_pkg::PosW-1] ? (~st_q[SIn].x + 1'b1) : st_q[SIn].x;
    ya = st_q[SIn].y[cfml_pkg::PosW-1] ? (~st_q[SIn].y + 1'b1) : st_q[SIn].y;
    st_d[SSq].xx = {{cfml_pkg::PosW{1'b0}}, xa} * {{cfml_pkg::PosW{1'b0}}, xa};
    st_d[SSq].yy = {{cfml_pkg::PosW{1'b0}}, ya} * {{cfml_pkg::PosW{1'b0}}, ya};
    st_d[SSq].zneg = st_q[SIn].z[cfml_pkg::PosW-1];
    st_d[SSq].zabs = st_q[SIn].z[cfml_pkg::PosW-1] ? (~st_q[SIn].z + 1'b1) : st_q[SIn].z;
    la = {8'b0, st_q[SIn].lrb} * 16'(cfml_pkg::AxialBins) + {8'b0, st_q[SIn].lab};
    st_d[SSq].ladr = la[cfml_pkg::AddrW-1:0];
    st_d[SSq].lok  = (st_q[SIn].lrb < cfml_pkg::BinW'(cfml_pkg::RadialBins)) &&
                     (st_q[SIn].lab < cfml_pkg::BinW'(cfml_pkg::AxialBins));
  end

  // Sum of squares; scale |z| by the reciprocal of one centimetre
  always_comb begin
    st_d[SSum]       = st_q[SSq];
    st_d[SSum].s     = st_q[SSq].xx + st_q[SSq].yy;
    st_d[SSum].zprod = {{cfml_pkg::PosW{1'b0}}, st_q[SSq].zabs} *
                       {{cfml_pkg::PosW{1'b0}}, cfml_pkg::ZbMul};
  end

  // Axial bin magnitude and sign; seed the square root
  always_comb begin
    st_d[SZb]      = st_q[SSum];
    st_d[SZb].za   = st_q[SSum].zprod[cfml_pkg::ZbShift +: cfml_pkg::ZbW];
    st_d[SZb].flip = st_q[SSum].zneg && (st_d[SZb].za != '0);
    st_d[SZb].rem  = '0;
    st_d[SZb].root = '0;
  end

  // Integer square root, one result bit per stage
  for (genvar g = 0; g < cfml_pkg::SqrtSteps; g++) begin : g_sqrt
    localparam int P = cfml_pkg::SqrtSteps - 1 - g;
    always_comb begin
      logic [cfml_pkg::RemW-1:0] rem_n;
      logic [cfml_pkg::RemW-1:0] trial;
      st_d[SqrtFirst+g] = st_q[SqrtFirst+g-1];
      rem_n = {st_q[SqrtFirst+g-1].rem[cfml_pkg::RemW-3:0],
               st_q[SqrtFirst+g-1].s[2*P+1 -: 2]};
      trial = {2'b00, st_q[SqrtFirst+g-1].root, 2'b01};
      if (rem_n >= trial) begin
        st_d[SqrtFirst+g].rem  = rem_n - trial;
        st_d[SqrtFirst+g].root = {st_q[SqrtFirst+g-1].root[cfml_pkg::RootW-2:0], 1'b1};
      end else begin
        st_d[SqrtFirst+g].rem  = rem_n;
        st_d[SqrtFirst+g].root = {st_q[SqrtFirst+g-1].root[cfml_pkg::RootW-2:0], 1'b0};
      end
    end
  end

  // Scale the root by the reciprocal of one millimetre
  always_comb begin
    st_d[SRbm]        = st_q[SRbm-1];
    st_d[SRbm].rbprod = {22'b0, st_q[SRbm-1].root} * {21'b0, cfml_pkg::RbMul};
  end

  // Classify: axis, map, edge column or outside
  always_comb begin
    logic [cfml_pkg::RbW-1:0] rb;
    st_d[SCls]      = st_q[SRbm];
    rb              = st_q[SRbm].rbprod[cfml_pkg::RbShift +: cfml_pkg::RbW];
    st_d[SCls].hit  = 1'b0;
    st_d[SCls].axis = 1'b0;
    st_d[SCls].col  = '0;
    if (st_q[SRbm].za < cfml_pkg::ZbW'(cfml_pkg::AxialBins)) begin
      if (rb == '0) begin
        st_d[SCls].hit  = 1'b1;
        st_d[SCls].axis = 1'b1;
      end else if (rb < cfml_pkg::RbW'(cfml_pkg::RadialBins)) begin
        st_d[SCls].hit = 1'b1;
        st_d[SCls].col = rb[cfml_pkg::BinW-1:0];
      end else if ((rb <= {3'b0, radius_limit_i}) &&
                   (st_q[SRbm].za < {3'b0, axial_limit_i})) begin
        st_d[SCls].hit = 1'b1;
        st_d[SCls].col = cfml_pkg::BinW'(cfml_pkg::RadialBins - 1);
      end
    end
  end

  // Hand the classified item to the queue
  always_comb begin
    logic [15:0] qa;
    qa = {8'b0, st_q[SCls].col} * 16'(cfml_pkg::AxialBins) + {5'b0, st_q[SCls].za};
    item_o.is_load = st_q[SCls].is_load;
    item_o.lok     = st_q[SCls].lok;
    item_o.addr    = st_q[SCls].is_load ? st_q[SCls].ladr : qa[cfml_pkg::AddrW-1:0];
    item_o.lrv     = st_q[SCls].lrv;
    item_o.lav     = st_q[SCls].lav;
    item_o.x       = st_q[SCls].x;
    item_o.y       = st_q[SCls].y;
    item_o.flip    = st_q[SCls].flip;
    item_o.s       = st_q[SCls].s;
    item_o.hit     = st_q[SCls].hit;
    item_o.axis    = st_q[SCls].axis;
  end

endmodule

`default_nettype wire

### hw/rtl/cfml_queue.sv
// Short queue of classified items between the front and back parts.
// Depends on cfml_pkg.
`default_nettype none

module cfml_queue (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push_i,
  input  cfml_pkg::cfml_item_t       item_i,
  output logic                       full_o,
  input  wire logic                  pop_i,
  output logic                       empty_o,
  output cfml_pkg::cfml_item_t       item_o
);

  cfml_pkg::cfml_item_t         mem_q [cfml_pkg::QDepth];
  logic [cfml_pkg::QPtrW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [cfml_pkg::QPtrW:0]     cnt_q, cnt_d;

  assign full_o  = (cnt_q == (cfml_pkg::QPtrW+1)'(cfml_pkg::QDepth));
  assign empty_o = (cnt_q == '0);
  assign item_o  = mem_q[rd_q];

  // Advance pointers and count
  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = pop_i ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/cfml_split.sv
// Exact split of one radial component: floor(a / sqrt(s)) from a^2 and s,
// one quotient bit per pipeline stage. Depends on cfml_pkg.
`default_nettype none

module cfml_split (
  input  wire logic                          clk_i,
  input  wire logic                          en_i,
  input  wire logic [cfml_pkg::Sq2W-1:0]     a2_i,
  input  wire logic [cfml_pkg::SqW-1:0]      s_i,
  output logic      [cfml_pkg::MagW-1:0]     q_o
);

  localparam int N = cfml_pkg::SplitSteps;

  typedef struct packed {
    logic [cfml_pkg::MagW-1:0]    q;
    logic [cfml_pkg::TW-1:0]      t;
    logic [cfml_pkg::RemSplW-1:0] r;
    logic [cfml_pkg::SqW-1:0]     s;
  } sp_t;

  sp_t st_q [N];
  sp_t st_d [N];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q <= st_d;
    end
  end

  // Try bit K: keep it when (q + 2^K)^2 * s still fits under a^2
  for (genvar j = 0; j < N; j++) begin : g_step
    localparam int K = N - 1 - j;
    always_comb begin
      sp_t                          prv;
      logic [cfml_pkg::RemSplW-1:0] dlt;
      if (j == 0) begin
        prv.q = '0;
        prv.t = '0;
        prv.r = {2'b00, a2_i};
        prv.s = s_i;
      end else begin
        prv = st_q[(j == 0) ? 0 : j-1];
      end
      dlt = ({{(cfml_pkg::RemSplW-cfml_pkg::TW){1'b0}}, prv.t} << (K+1)) +
            ({{(cfml_pkg::RemSplW-cfml_pkg::SqW){1'b0}}, prv.s} << (2*K));
      st_d[j] = prv;
      if (prv.r >= dlt) begin
        st_d[j].r    = prv.r - dlt;
        st_d[j].t    = prv.t + ({{(cfml_pkg::TW-cfml_pkg::SqW){1'b0}}, prv.s} << K);
        st_d[j].q[K] = 1'b1;
      end
    end
  end

  assign q_o = st_q[N-1].q;

endmodule

`default_nettype wire

### hw/rtl/cfml_back.sv
// Back part: loads and reads the field maps, splits the radial field,
// drives the output register. Depends on cfml_pkg, cfml_ram and cfml_split.
`default_nettype none

module cfml_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          q_empty_i,
  input  cfml_pkg::cfml_item_t               q_item_i,
  output logic                               pop_o,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [cfml_pkg::FieldW-1:0]        field_x_o,
  output logic [cfml_pkg::FieldW-1:0]        field_y_o,
  output logic [cfml_pkg::FieldW-1:0]        field_z_o,
  output logic                               inside_map_o
);

  localparam int N = cfml_pkg::SplitSteps;
  localparam logic [cfml_pkg::FieldW-1:0] FieldMax = {1'b0, {(cfml_pkg::FieldW-1){1'b1}}};

  typedef struct packed {
    logic signed [cfml_pkg::PosW-1:0] x;
    logic signed [cfml_pkg::PosW-1:0] y;
    logic                             flip;
    logic [cfml_pkg::SqW-1:0]         s;
    logic                             hit;
    logic                             axis;
    logic [cfml_pkg::MagW-1:0]        em;
    logic                             eneg;
    logic [cfml_pkg::FieldW-1:0]      fz;
    logic                             negx;
    logic                             negy;
    logic [cfml_pkg::ProdW-1:0]       ax;
    logic [cfml_pkg::ProdW-1:0]       ay;
    logic [2*cfml_pkg::HiW-1:0]       hhx, hhy;
    logic [cfml_pkg::HiW+cfml_pkg::LoW-1:0] hlx, hly;
    logic [2*cfml_pkg::LoW-1:0]       llx, lly;
    logic [cfml_pkg::Sq2W-1:0]        a2x, a2y;
  } bk_t;

  typedef struct packed {
    logic                        hit;
    logic                        axis;
    logic                        negx;
    logic                        negy;
    logic [cfml_pkg::FieldW-1:0] fz;
  } meta_t;

  logic                        en;
  logic [cfml_pkg::FieldW-1:0] rd_rad, rd_ax;
  cfml_pkg::cfml_item_t        p0_q;
  bk_t                         p1_q, p1_d, p2_q, p2_d, p3_q, p3_d, p4_q, p4_d;
  logic [4:0]                  pv_q;
  meta_t                       m_q [N];
  logic [N-1:0]                mv_q;
  logic [cfml_pkg::MagW-1:0]   qx, qy;
  logic                        out_valid_q;
  logic [cfml_pkg::FieldW-1:0] fx_q, fy_q, fz_q, fx_d, fy_d, fz_d;
  logic                        in_q;

  // Stall the whole back part while a result waits at the output
  assign en    = !out_valid_q || out_ready_i;
  assign pop_o = en && !q_empty_i;

  cfml_ram #(.Width(cfml_pkg::FieldW), .Depth(cfml_pkg::MapDepth)) u_radial (
    .clk_i   (clk_i),
    .we_i    (pop_o && q_item_i.is_load && q_item_i.lok),
    .re_i    (en),
    .addr_i  (q_item_i.addr),
    .wdata_i (q_item_i.lrv),
    .rdata_o (rd_rad)
  );

  cfml_ram #(.Width(cfml_pkg::FieldW), .Depth(cfml_pkg::MapDepth)) u_axial (
    .clk_i   (clk_i),
    .we_i    (pop_o && q_item_i.is_load && q_item_i.lok),
    .re_i    (en),
    .addr_i  (q_item_i.addr),
    .wdata_i (q_item_i.lav),
    .rdata_o (rd_ax)
  );

  // Take the map entries and the field magnitude
  always_comb begin
    p1_d      = '0;
    p1_d.x    = p0_q.x;
    p1_d.y    = p0_q.y;
    p1_d.flip = p0_q.flip;
    p1_d.s    = p0_q.s;
    p1_d.hit  = p0_q.hit;
    p1_d.axis = p0_q.axis;
    p1_d.eneg = rd_rad[cfml_pkg::FieldW-1];
    p1_d.em   = rd_rad[cfml_pkg::FieldW-1] ? (~rd_rad + 1'b1) : rd_rad;
    p1_d.fz   = rd_ax;
  end

  // Multiply the magnitude by |x| and |y|
  always_comb begin
    logic [cfml_pkg::PosW-1:0] xa;
    logic [cfml_pkg::PosW-1:0] ya;
    p2_d = p1_q;
    xa = p1_q.x[cfml_pkg::PosW-1] ? (~p1_q.x + 1'b1) : p1_q.x;
    ya = p1_q.y[cfml_pkg::PosW-1] ? (~p1_q.y + 1'b1) : p1_q.y;
    p2_d.ax   = {{cfml_pkg::PosW{1'b0}}, p1_q.em} * {{cfml_pkg::MagW{1'b0}}, xa};
    p2_d.ay   = {{cfml_pkg::PosW{1'b0}}, p1_q.em} * {{cfml_pkg::MagW{1'b0}}, ya};
    p2_d.negx = p1_q.eneg ^ p1_q.x[cfml_pkg::PosW-1] ^ p1_q.flip;
    p2_d.negy = p1_q.eneg ^ p1_q.y[cfml_pkg::PosW-1] ^ p1_q.flip;
  end

  // Partial products of the squares
  always_comb begin
    logic [cfml_pkg::HiW-1:0] hx, hy;
    logic [cfml_pkg::LoW-1:0] lx, ly;
    p3_d = p2_q;
    hx = p2_q.ax[cfml_pkg::ProdW-1:cfml_pkg::LoW];
    lx = p2_q.ax[cfml_pkg::LoW-1:0];
    hy = p2_q.ay[cfml_pkg::ProdW-1:cfml_pkg::LoW];
    ly = p2_q.ay[cfml_pkg::LoW-1:0];
    p3_d.hhx = {{cfml_pkg::HiW{1'b0}}, hx} * {{cfml_pkg::HiW{1'b0}}, hx};
    p3_d.hhy = {{cfml_pkg::HiW{1'b0}}, hy} * {{cfml_pkg::HiW{1'b0}}, hy};
    p3_d.hlx = {{cfml_pkg::LoW{1'b0}}, hx} * {{cfml_pkg::HiW{1'b0}}, lx};
    p3_d.hly = {{cfml_pkg::LoW{1'b0}}, hy} * {{cfml_pkg::HiW{1'b0}}, ly};
    p3_d.llx = {{cfml_pkg::LoW{1'b0}}, lx} * {{cfml_pkg::LoW{1'b0}}, lx};
    p3_d.lly = {{cfml_pkg::LoW{1'b0}}, ly} * {{cfml_pkg::LoW{1'b0}}, ly};
  end

  // Sum the partial products into the squares
  always_comb begin
    p4_d = p3_q;
    p4_d.a2x = ({{(cfml_pkg::Sq2W-2*cfml_pkg::HiW){1'b0}}, p3_q.hhx} << (2*cfml_pkg::LoW)) +
               ({{(cfml_pkg::Sq2W-cfml_pkg::ProdW){1'b0}}, p3_q.hlx} << (cfml_pkg::LoW+1)) +
               {{(cfml_pkg::Sq2W-2*cfml_pkg::LoW){1'b0}}, p3_q.llx};
    p4_d.a2y = ({{(cfml_pkg::Sq2W-2*cfml_pkg::HiW){1'b0}}, p3_q.hhy} << (2*cfml_pkg::LoW)) +
               ({{(cfml_pkg::Sq2W-cfml_pkg::ProdW){1'b0}}, p3_q.hly} << (cfml_pkg::LoW+1)) +
               {{(cfml_pkg::Sq2W-2*cfml_pkg::LoW){1'b0}}, p3_q.lly};
  end

  cfml_split u_split_x (
    .clk_i (clk_i),
    .en_i  (en),
    .a2_i  (p4_q.a2x),
    .s_i   (p4_q.s),
    .q_o   (qx)
  );

  cfml_split u_split_y (
    .clk_i (clk_i),
    .en_i  (en),
    .a2_i  (p4_q.a2y),
    .s_i   (p4_q.s),
    .q_o   (qy)
  );

  // Apply sign, saturate positive results, and zero outside the mapped regions
  always_comb begin
    fx_d = '0;
    fy_d = '0;
    fz_d = m_q[N-1].hit ? m_q[N-1].fz : '0;
    if (m_q[N-1].hit && !m_q[N-1].axis) begin
      if (m_q[N-1].negx) begin
        fx_d = ~qx + 1'b1;
      end else begin
        fx_d = qx[cfml_pkg::MagW-1] ? FieldMax : qx;
      end
      if (m_q[N-1].negy) begin
        fy_d = ~qy + 1'b1;
      end else begin
        fy_d = qy[cfml_pkg::MagW-1] ? FieldMax : qy;
      end
    end
  end

  // Valid bits of every stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q        <= '0;
      mv_q        <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      pv_q        <= {pv_q[3:0], pop_o && !q_item_i.is_load};
      mv_q        <= {mv_q[N-2:0], pv_q[4]};
      out_valid_q <= mv_q[N-1];
    end
  end

  // Stage payloads
  always_ff @(posedge clk_i) begin
    if (en) begin
      p0_q    <= q_item_i;
      p1_q    <= p1_d;
      p2_q    <= p2_d;
      p3_q    <= p3_d;
      p4_q    <= p4_d;
      m_q[0]  <= '{hit: p4_q.hit, axis: p4_q.axis, negx: p4_q.negx,
                   negy: p4_q.negy, fz: p4_q.fz};
      for (int i = 1; i < N; i++) begin
        m_q[i] <= m_q[i-1];
      end
      fx_q <= fx_d;
      fy_q <= fy_d;
      fz_q <= fz_d;
      in_q <= m_q[N-1].hit;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign field_x_o    = fx_q;
  assign field_y_o    = fy_q;
  assign field_z_o    = fz_q;
  assign inside_map_o = in_q;

endmodule

`default_nettype wire

### hw/rtl/cylindrical_field_map_lookup.sv
// Throughput: one request per cycle unless back-pressure from the result stream
// fills the queue; the square root, the map read and the 32-stage radial split
// are all fully pipelined, a four-entry queue parts them.
// Reset: async active low clears control state and sets the limits to 900 / 100;
// the map contents are undefined until loaded. Depends on cfml_pkg, cfml_front,
// cfml_queue and cfml_back.
`default_nettype none

module cylindrical_field_map_lookup (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // request stream
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // pos_x[20:0], pos_y[41:21], pos_z[62:42], load_radial_bin[70:63],
  // load_axial_bin[78:71], load_radial_value[110:79], load_axial_value[142:111]
  input  wire logic [143:0]                  s_axis_tdata,
  // op[0]
  input  wire logic                          s_axis_tuser,
  // result stream
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // field_x[31:0], field_y[63:32], field_z[95:64]
  output logic [95:0]                        m_axis_tdata,
  // inside_map[0]
  output logic                               m_axis_tuser,
  // configuration writes
  input  wire logic                          cfg_we_i,
  input  wire logic [cfml_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [cfml_pkg::RLimW-1:0]    cfg_data_i
);

  logic [cfml_pkg::RLimW-1:0] rlim_q;
  logic [cfml_pkg::ZLimW-1:0] zlim_q;
  logic                       push, full, pop, empty;
  cfml_pkg::cfml_item_t       f_item, b_item;
  logic [cfml_pkg::FieldW-1:0] fx, fy, fz;

  // Hold the limit registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rlim_q <= cfml_pkg::RadiusLimitRst;
      zlim_q <= cfml_pkg::AxialLimitRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        cfml_pkg::CfgRadiusLimit: rlim_q <= cfg_data_i;
        cfml_pkg::CfgAxialLimit:  zlim_q <= cfg_data_i[cfml_pkg::ZLimW-1:0];
        default: ;
      endcase
    end
  end

  cfml_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .in_op_i        (s_axis_tuser),
    .in_x_i         (s_axis_tdata[20:0]),
    .in_y_i         (s_axis_tdata[41:21]),
    .in_z_i         (s_axis_tdata[62:42]),
    .in_lrb_i       (s_axis_tdata[70:63]),
    .in_lab_i       (s_axis_tdata[78:71]),
    .in_lrv_i       (s_axis_tdata[110:79]),
    .in_lav_i       (s_axis_tdata[142:111]),
    .radius_limit_i (rlim_q),
    .axial_limit_i  (zlim_q),
    .q_full_i       (full),
    .push_o         (push),
    .item_o         (f_item)
  );

  cfml_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (f_item),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .item_o  (b_item)
  );

  cfml_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (empty),
    .q_item_i     (b_item),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .field_x_o    (fx),
    .field_y_o    (fy),
    .field_z_o    (fz),
    .inside_map_o (m_axis_tuser)
  );

  assign m_axis_tdata = {fz, fy, fx};

endmodule

`default_nettype wire
